// ===== hw/rtl/whdm_pkg.sv =====
// Shared types, status codes and compare helpers for the wire-hit merger.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
package whdm_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_VIEW    = 3'd1;
  localparam logic [2:0] ST_PITCH   = 3'd2;
  localparam logic [2:0] ST_MIXED   = 3'd3;
  localparam logic [2:0] ST_OVFL    = 3'd4;

  localparam logic [1:0] VIEW_U     = 2'd0;
  localparam logic [1:0] VIEW_V     = 2'd1;
  localparam logic [1:0] VIEW_W     = 2'd2;
  localparam logic [1:0] VIEW_OTHER = 2'd3;

  localparam logic [1:0] CFG_PITCH_U = 2'd0;
  localparam logic [1:0] CFG_PITCH_V = 2'd1;
  localparam logic [1:0] CFG_PITCH_W = 2'd2;
  localparam logic [1:0] CFG_DRIFT   = 2'd3;

  typedef struct packed {
    logic signed [15:0] wire_no;
    logic signed [31:0] x;
    logic [31:0]        energy;
    logic [31:0]        id;
    logic [31:0]        tid;
  } hit_t;

  typedef struct packed {
    hit_t       hit;
    logic [1:0] view;
    logic [2:0] status;
    logic       last;
  } item_t;

  // Sort order: wire, then x, then energy.
  function automatic logic hit_less(input hit_t a, input hit_t b);
    logic res;
    if (a.wire_no != b.wire_no) res = a.wire_no < b.wire_no;
    else if (a.x != b.x) res = a.x < b.x;
    else res = a.energy < b.energy;
    return res;
  endfunction

  // True when cell b lies after a merged hit a in (wire, x) order.
  function automatic logic hit_after(input hit_t a, input hit_t b);
    return (b.wire_no > a.wire_no) || ((b.wire_no == a.wire_no) && (b.x > a.x));
  endfunction

endpackage

// ===== hw/rtl/whdm_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Uses no package; instantiated by the front and back parts.
module whdm_div #(
  parameter int NW = 34,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   quo_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic            busy_r;
  logic            done_r;
  logic [DW:0]     trial;
  logic [DW+1:0]   diff;
  logic            take;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = {1'b0, trial} - {2'b0, den_r};
  assign take  = !diff[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CNTW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[NW-2:0], take};
        rem_r <= take ? diff[DW-1:0] : trial[DW-1:0];
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

// ===== hw/rtl/whdm_front.sv =====
// Front part: takes hit requests, checks the frame, snaps z to a wire number.
// Depends on whdm_pkg and whdm_div.
module whdm_front #(
  parameter int MAX_HITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_z,
  input  logic [31:0]         in_energy,
  input  logic [1:0]          in_view,
  input  logic [31:0]         in_id,
  input  logic [31:0]         in_tid,
  input  logic                in_last,
  input  logic [31:0]         pitch_u,
  input  logic [31:0]         pitch_v,
  input  logic [31:0]         pitch_w,
  output logic                push_valid,
  input  logic                push_ready,
  output whdm_pkg::item_t     push_item
);
  localparam int CW = $clog2(MAX_HITS + 1);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t          state_r;
  logic [CW-1:0]    hit_count_r;
  logic [1:0]       frame_view_r;
  logic [2:0]       frame_error_r;
  whdm_pkg::item_t  item_r;
  logic signed [31:0] x_r;
  logic [31:0]      energy_r, id_r, tid_r;
  logic             last_r, neg_r;

  logic             accept;
  logic [2:0]       fe_acc;
  logic [1:0]       fv_acc;
  logic [31:0]      pitch_sel;
  logic             go_div;
  logic signed [34:0] num_s;
  logic [33:0]      mag;
  logic [33:0]      quo;
  logic [32:0]      rem;
  logic             div_done, div_busy;
  logic [34:0]      val;
  logic             in_range;
  logic [15:0]      wire_w;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    fe_acc = frame_error_r;
    fv_acc = frame_view_r;
    go_div = 1'b0;
    if (fe_acc == whdm_pkg::ST_OK) begin
      if (hit_count_r == '0) begin
        if (in_view == whdm_pkg::VIEW_OTHER) fe_acc = whdm_pkg::ST_VIEW;
        else fv_acc = in_view;
      end else if (in_view != frame_view_r) begin
        fe_acc = whdm_pkg::ST_MIXED;
      end
    end
    case (fv_acc)
      whdm_pkg::VIEW_U: pitch_sel = pitch_u;
      whdm_pkg::VIEW_V: pitch_sel = pitch_v;
      default:          pitch_sel = pitch_w;
    endcase
    if (fe_acc == whdm_pkg::ST_OK) begin
      if (pitch_sel == '0) fe_acc = whdm_pkg::ST_PITCH;
      else if (hit_count_r >= CW'(MAX_HITS)) fe_acc = whdm_pkg::ST_OVFL;
      else go_div = 1'b1;
    end
  end

  // wire = floor((2z + p) / 2p), divided on magnitudes and fixed up for sign.
  assign num_s = {{2{in_z[31]}}, in_z, 1'b0} + {3'b0, pitch_sel};
  assign mag   = num_s[34] ? 34'(-num_s) : num_s[33:0];

  whdm_div #(.NW(34), .DW(33)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && go_div),
    .num   (mag),
    .den   ({pitch_sel, 1'b0}),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo),
    .rem   (rem)
  );

  assign val      = {1'b0, quo} + {34'b0, (rem != '0)};
  assign in_range = neg_r ? (val <= 35'd32768) : (quo <= 34'd32767);
  assign wire_w   = neg_r ? 16'(-val[15:0]) : quo[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= F_IDLE;
      hit_count_r   <= '0;
      frame_view_r  <= '0;
      frame_error_r <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            frame_view_r  <= fv_acc;
            frame_error_r <= fe_acc;
            x_r      <= in_x;
            energy_r <= in_energy;
            id_r     <= in_id;
            tid_r    <= in_tid;
            last_r   <= in_last;
            neg_r    <= num_s[34];
            if (go_div) begin
              state_r <= F_DIV;
            end else if (in_last) begin
              item_r        <= '0;
              item_r.status <= fe_acc;
              item_r.last   <= 1'b1;
              state_r       <= F_PUSH;
            end
          end
        end
        F_DIV: begin
          if (div_done) begin
            if (in_range) begin
              item_r.hit    <= '{wire_no: wire_w, x: x_r, energy: energy_r,
                                 id: id_r, tid: tid_r};
              item_r.view   <= frame_view_r;
              item_r.status <= whdm_pkg::ST_OK;
              item_r.last   <= last_r;
              hit_count_r   <= hit_count_r + CW'(1);
              state_r       <= F_PUSH;
            end else begin
              frame_error_r <= whdm_pkg::ST_OVFL;
              if (last_r) begin
                item_r        <= '0;
                item_r.status <= whdm_pkg::ST_OVFL;
                item_r.last   <= 1'b1;
                state_r       <= F_PUSH;
              end else begin
                state_r <= F_IDLE;
              end
            end
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            if (item_r.last) begin
              hit_count_r   <= '0;
              frame_view_r  <= '0;
              frame_error_r <= '0;
            end
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign push_valid = (state_r == F_PUSH);
  assign push_item  = item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hit_count_r <= CW'(MAX_HITS)) else $error("front hit count above limit");
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && item_r.status != whdm_pkg::ST_OK) |-> item_r.last)
    else $error("error request not marked last");
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy) else $error("divider busy while front idle");
endmodule

// ===== hw/rtl/whdm_queue.sv =====
// Two-entry queue between the front and back parts.
// Depends on whdm_pkg for the request type.
module whdm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  whdm_pkg::item_t  push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output whdm_pkg::item_t  pop_item
);
  whdm_pkg::item_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// ===== hw/rtl/whdm_back.sv =====
// Back part: keeps the frame sorted in a row of cells, merges close hits, emits.
// Depends on whdm_pkg and whdm_div.
module whdm_back #(
  parameter int MAX_HITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      drift_width,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  whdm_pkg::item_t  pop_item,
  output logic             out_valid,
  input  logic             out_ready,
  output whdm_pkg::item_t  out_item
);
  localparam int CW = $clog2(MAX_HITS + 1);

  typedef enum logic [3:0] {
    B_LOAD, B_FLAG, B_PICK, B_GRAB, B_MATH, B_MUL, B_DSTART, B_DWAIT, B_INS,
    B_OUT, B_ERR
  } bstate_t;

  bstate_t          state_r;
  whdm_pkg::hit_t   cells_r   [MAX_HITS];
  whdm_pkg::hit_t   cells_nxt [MAX_HITS];
  logic [CW-1:0]    n_r;
  logic [MAX_HITS-1:0] flags_c, flags_r, onehot_c, onehot_r, tail_mask;
  logic [MAX_HITS-1:0] ins_ge;
  whdm_pkg::hit_t   a_r, b_r, a_sel, b_sel, ins_hit, m_hit;
  logic signed [31:0] lo_x_r, m_x_r;
  logic [31:0]      d_r, hi_e_r, me_r, mid_r, mtid_r;
  logic [32:0]      sum_r;
  logic [63:0]      prod_r;
  logic [1:0]       view_r;
  logic [2:0]       err_r;
  whdm_pkg::item_t  out_r;
  logic             out_valid_r;
  logic             out_free;
  logic             div_done, div_busy;
  logic [63:0]      quo;
  logic [32:0]      rem;

  logic             lo_is_a;
  logic signed [32:0] dx_ab;
  logic [32:0]      sum_ab;

  assign pop_ready = (state_r == B_LOAD);
  assign out_free  = !out_valid_r || out_ready;
  assign m_hit     = '{wire_no: a_r.wire_no, x: m_x_r, energy: me_r, id: mid_r, tid: mtid_r};
  assign ins_hit   = (state_r == B_INS) ? m_hit : pop_item.hit;

  // One flag per neighbor pair of the same wire that lies within the drift width.
  always_comb begin
    logic signed [32:0] dx;
    logic [32:0] adx;
    flags_c = '0;
    for (int i = 0; i < MAX_HITS - 1; i++) begin
      dx  = 33'(cells_r[i].x) - 33'(cells_r[i+1].x);
      adx = dx[32] ? 33'(-dx) : 33'(dx);
      flags_c[i] = (CW'(i + 1) < n_r) && (cells_r[i].wire_no == cells_r[i+1].wire_no)
                   && (adx < {1'b0, drift_width});
    end
  end

  assign onehot_c  = flags_r & (~flags_r + MAX_HITS'(1));
  assign tail_mask = ~(onehot_r - MAX_HITS'(1));

  always_comb begin
    a_sel = '0;
    b_sel = '0;
    for (int i = 0; i < MAX_HITS - 1; i++) begin
      if (onehot_r[i]) begin
        a_sel = a_sel | cells_r[i];
        b_sel = b_sel | cells_r[i+1];
      end
    end
  end

  // Insertion point: the first cell that must sit after the new hit.
  always_comb begin
    for (int i = 0; i < MAX_HITS; i++) begin
      if (CW'(i) < n_r)
        ins_ge[i] = (state_r == B_INS) ? whdm_pkg::hit_after(ins_hit, cells_r[i])
                                       : whdm_pkg::hit_less(ins_hit, cells_r[i]);
      else
        ins_ge[i] = (CW'(i) == n_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_HITS; i++) begin
      cells_nxt[i] = cells_r[i];
      case (state_r)
        B_LOAD, B_INS: begin
          if (ins_ge[i]) begin
            if (i > 0 && ins_ge[i-1]) cells_nxt[i] = cells_r[i-1];
            else cells_nxt[i] = ins_hit;
          end
        end
        B_GRAB: begin
          if (tail_mask[i] && i + 2 < MAX_HITS) cells_nxt[i] = cells_r[i+2];
        end
        B_OUT: begin
          if (i + 1 < MAX_HITS) cells_nxt[i] = cells_r[i+1];
        end
        default: cells_nxt[i] = cells_r[i];
      endcase
    end
  end

  assign lo_is_a = (a_r.x <= b_r.x);
  assign dx_ab   = lo_is_a ? (33'(b_r.x) - 33'(a_r.x)) : (33'(a_r.x) - 33'(b_r.x));
  assign sum_ab  = {1'b0, a_r.energy} + {1'b0, b_r.energy};

  whdm_div #(.NW(64), .DW(33)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == B_DSTART),
    .num   (prod_r),
    .den   (sum_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo),
    .rem   (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_LOAD;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        B_LOAD: begin
          if (pop_valid) begin
            view_r <= pop_item.view;
            if (pop_item.status != whdm_pkg::ST_OK) begin
              err_r   <= pop_item.status;
              state_r <= B_ERR;
            end else begin
              n_r <= n_r + CW'(1);
              if (pop_item.last) state_r <= B_FLAG;
            end
          end
        end
        B_FLAG: begin
          flags_r <= flags_c;
          state_r <= B_PICK;
        end
        B_PICK: begin
          onehot_r <= onehot_c;
          state_r  <= (flags_r == '0) ? B_OUT : B_GRAB;
        end
        B_GRAB: begin
          a_r     <= a_sel;
          b_r     <= b_sel;
          n_r     <= n_r - CW'(2);
          state_r <= B_MATH;
        end
        B_MATH: begin
          lo_x_r  <= lo_is_a ? a_r.x : b_r.x;
          hi_e_r  <= lo_is_a ? b_r.energy : a_r.energy;
          d_r     <= dx_ab[31:0];
          sum_r   <= sum_ab;
          me_r    <= sum_ab[32] ? 32'hFFFF_FFFF : sum_ab[31:0];
          mid_r   <= (a_r.energy > b_r.energy) ? a_r.id : b_r.id;
          mtid_r  <= (a_r.energy > b_r.energy) ? a_r.tid : b_r.tid;
          state_r <= B_MUL;
        end
        B_MUL: begin
          prod_r <= d_r * hi_e_r;
          if (sum_r == '0) begin
            m_x_r   <= lo_x_r + $signed({1'b0, d_r[31:1]});
            state_r <= B_INS;
          end else begin
            state_r <= B_DSTART;
          end
        end
        B_DSTART: state_r <= B_DWAIT;
        B_DWAIT: begin
          if (div_done) begin
            m_x_r   <= lo_x_r + $signed(quo[31:0]);
            state_r <= B_INS;
          end
        end
        B_INS: begin
          n_r     <= n_r + CW'(1);
          state_r <= B_FLAG;
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_r.hit     <= cells_r[0];
            out_r.view    <= view_r;
            out_r.status  <= whdm_pkg::ST_OK;
            out_r.last    <= (n_r == CW'(1));
            n_r           <= n_r - CW'(1);
            if (n_r == CW'(1)) state_r <= B_LOAD;
          end
        end
        B_ERR: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_r        <= '0;
            out_r.status <= err_r;
            out_r.last   <= 1'b1;
            n_r          <= '0;
            state_r      <= B_LOAD;
          end
        end
        default: state_r <= B_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_HITS; i++) begin
      if ((state_r == B_LOAD && pop_valid && pop_item.status == whdm_pkg::ST_OK) ||
          state_r == B_INS || state_r == B_GRAB || (state_r == B_OUT && out_free))
        cells_r[i] <= cells_nxt[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MAX_HITS)) else $error("cell count above limit");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != whdm_pkg::ST_OK) |-> out_r.last)
    else $error("error result not last");
  a_grab_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_GRAB) |=> (n_r == $past(n_r) - CW'(2)))
    else $error("pair removal count wrong");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DWAIT && !div_done) |-> div_busy)
    else $error("waiting on idle divider");
endmodule

// ===== hw/rtl/wire_hit_downsample_merge.sv =====
// Wire-hit downsampler and merger, top level with the configuration registers.
// Depends on whdm_pkg, whdm_front, whdm_queue and whdm_back.
//
// A frame of hits streams in, one request per hit, the last one flagged on tlast.
// Each accepted hit passes through the serial divider in the front part, which snaps
// z to a wire number; a hit that is rejected skips the divider. The back part
// keeps the hits sorted in a row of cells as they arrive; after the last hit it
// merges one close pair per round, with the 64-step serial divider for the weighted
// mean and a search for the pair in each round. Results then leave one per cycle
// while the output is not held. A frame with an error gives one result that
// carries the status. The front takes the next frame's hits while the back
// is still busy, until the two-entry queue between them fills.
module wire_hit_downsample_merge #(
  parameter int MAX_HITS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // hit_x, hit_z, hit_energy, hit_id, truth_id
  input  logic [1:0]   in_tuser,   // hit_view
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // out_wire, out_x, out_energy, out_id, out_truth_id
  output logic [4:0]   out_tuser,  // out_view, status
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  logic [31:0] pitch_u_r, pitch_v_r, pitch_w_r, drift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_u_r <= 32'h0001_0000;
      pitch_v_r <= 32'h0001_0000;
      pitch_w_r <= 32'h0001_0000;
      drift_r   <= 32'h0001_0000;
    end else if (cfg_we) begin
      case (cfg_addr)
        whdm_pkg::CFG_PITCH_U: pitch_u_r <= cfg_wdata;
        whdm_pkg::CFG_PITCH_V: pitch_v_r <= cfg_wdata;
        whdm_pkg::CFG_PITCH_W: pitch_w_r <= cfg_wdata;
        whdm_pkg::CFG_DRIFT:   drift_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic            q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  whdm_pkg::item_t q_push_item, q_pop_item, res_item;

  whdm_front #(.MAX_HITS(MAX_HITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_x       (in_tdata[31:0]),
    .in_z       (in_tdata[63:32]),
    .in_energy  (in_tdata[95:64]),
    .in_view    (in_tuser),
    .in_id      (in_tdata[127:96]),
    .in_tid     (in_tdata[159:128]),
    .in_last    (in_tlast),
    .pitch_u    (pitch_u_r),
    .pitch_v    (pitch_v_r),
    .pitch_w    (pitch_w_r),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item)
  );

  whdm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  whdm_back #(.MAX_HITS(MAX_HITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .drift_width (drift_r),
    .pop_valid   (q_pop_valid),
    .pop_ready   (q_pop_ready),
    .pop_item    (q_pop_item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_item    (res_item)
  );

  assign out_tdata = {res_item.hit.tid, res_item.hit.id, res_item.hit.energy,
                      res_item.hit.x, res_item.hit.wire_no};
  assign out_tuser = {res_item.status, res_item.view};
  assign out_tlast = res_item.last;
endmodule
